FILE: rtl/core/tile_slot_cache_allocator_assert.svh
// Assertion macros shared by the tile slot cache allocator RTL.
`ifndef TILE_SLOT_CACHE_ALLOCATOR_ASSERT_SVH
`define TILE_SLOT_CACHE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTH
// A property that must hold at every rising edge outside reset.
`define TSCA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tsca: assertion failed");
// A condition that must never be seen at a rising edge outside reset.
`define TSCA_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tsca: forbidden condition seen");
`else
`define TSCA_ASSERT(label, clk, rst_n, prop)
`define TSCA_NEVER(label, clk, rst_n, cond)
`endif

`endif

FILE: rtl/core/tsca_pkg.sv
// Shared constants, types and helpers for the tile slot cache allocator.
package tsca_pkg;

	localparam int TILES_PER_SIDE = 8;
	localparam int SLOT_COUNT     = TILES_PER_SIDE * TILES_PER_SIDE;
	localparam int SLOT_W         = $clog2(SLOT_COUNT);
	localparam int COUNT_W        = SLOT_W + 1;
	localparam int POS_W          = 3;
	localparam int KEY_W          = 19;
	localparam int ACT_W          = 2;
	localparam int SRC_W          = 8;
	localparam int PAGE_W         = 8;
	localparam int TILE_W         = 11;

	// Multiplier that spreads pages apart in the key space.
	localparam logic [15:0] TILES_PER_PAGE_KEY = 16'd1255;

	// Action codes carried with each request.
	localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd0;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_UPLOAD  = 2'd2;

	// One request as seen by the sequencer, key already formed.
	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [SRC_W-1:0] source_id;
		logic [KEY_W-1:0] key;
	} req_t;

	// One stored slot entry.
	typedef struct packed {
		logic [SRC_W-1:0] source;
		logic [KEY_W-1:0] key;
	} entry_t;

	// One result.
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              fetch_needed;
		logic              flushed;
		logic [POS_W-1:0]  slot_column;
		logic [POS_W-1:0]  slot_row;
		logic              was_dirty;
	} res_t;

	// Column of a slot within the page.
	function automatic logic [POS_W-1:0] slot_col(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] c;
		c = s % SLOT_W'(TILES_PER_SIDE);
		return POS_W'(c);
	endfunction

	// Row of a slot within the page.
	function automatic logic [POS_W-1:0] slot_rw(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		r = s / SLOT_W'(TILES_PER_SIDE);
		return POS_W'(r);
	endfunction

endpackage

FILE: rtl/core/tsca_slot_mem.sv
// Slot tag memory: one write port, one registered read port.
module tsca_slot_mem (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [tsca_pkg::SLOT_W-1:0]   wr_addr,
	input  tsca_pkg::entry_t              wr_data,
	input  logic [tsca_pkg::SLOT_W-1:0]   rd_addr,
	output tsca_pkg::entry_t              rd_data
);
	import tsca_pkg::*;

	entry_t mem [SLOT_COUNT];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: rtl/core/tsca_seq.sv
// Lookup and allocation sequencer around one shared tag comparator.
`include "tile_slot_cache_allocator_assert.svh"

module tsca_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  tsca_pkg::req_t                req,
	input  logic                          out_free,
	output logic                          idle,
	output logic                          done,
	output tsca_pkg::res_t                res,
	output logic                          wr_en,
	output logic [tsca_pkg::SLOT_W-1:0]   wr_addr,
	output tsca_pkg::entry_t              wr_data,
	output logic [tsca_pkg::SLOT_W-1:0]   rd_addr,
	input  tsca_pkg::entry_t              rd_data
);
	import tsca_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_LAST, ST_SCAN, ST_ALLOC, ST_DONE} state_t;

	state_t             state_q;
	logic [SRC_W-1:0]   src_q;
	logic [KEY_W-1:0]   key_q;
	logic [COUNT_W-1:0] count_q;
	logic [SLOT_W-1:0]  last_slot_q;
	logic               last_valid_q;
	logic               dirty_q;
	logic [COUNT_W-1:0] scan_idx_q;
	logic               cmp_valid_q;
	logic [SLOT_W-1:0]  cmp_idx_q;
	res_t               res_q;

	logic               match;
	logic               full;
	logic [SLOT_W-1:0]  alloc_idx;

	// Shared comparator on the entry just read.
	assign match = (rd_data.source == src_q) && (rd_data.key == key_q);

	// Allocation target; a full page restarts at slot 0.
	assign full      = (count_q >= COUNT_W'(SLOT_COUNT));
	assign alloc_idx = full ? '0 : count_q[SLOT_W-1:0];

	// Memory ports.
	assign rd_addr = (state_q == ST_IDLE) ? last_slot_q : scan_idx_q[SLOT_W-1:0];
	assign wr_en   = (state_q == ST_ALLOC);
	assign wr_addr = alloc_idx;
	assign wr_data = '{source: src_q, key: key_q};

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res  = res_q;

	// State machine with registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			src_q        <= '0;
			key_q        <= '0;
			count_q      <= '0;
			last_slot_q  <= '0;
			last_valid_q <= 1'b0;
			dirty_q      <= 1'b0;
			scan_idx_q   <= '0;
			cmp_valid_q  <= 1'b0;
			cmp_idx_q    <= '0;
			res_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						src_q <= req.source_id;
						key_q <= req.key;
						case (req.action)
							ACT_REQUEST: begin
								res_q   <= '0;
								state_q <= ST_LAST;
							end
							ACT_RELEASE: begin
								res_q        <= '0;
								count_q      <= '0;
								last_slot_q  <= '0;
								last_valid_q <= 1'b0;
								state_q      <= ST_DONE;
							end
							ACT_UPLOAD: begin
								res_q   <= '{was_dirty: dirty_q, default: '0};
								dirty_q <= 1'b0;
								state_q <= ST_DONE;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_LAST: begin
					// The last-hit slot was read in the accept cycle.
					if (last_valid_q && match) begin
						res_q.hit         <= 1'b1;
						res_q.slot        <= last_slot_q;
						res_q.slot_column <= slot_col(last_slot_q);
						res_q.slot_row    <= slot_rw(last_slot_q);
						state_q           <= ST_DONE;
					end else begin
						scan_idx_q  <= '0;
						cmp_valid_q <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// One read issued and one compare done per cycle.
					if (cmp_valid_q && match) begin
						res_q.hit         <= 1'b1;
						res_q.slot        <= cmp_idx_q;
						res_q.slot_column <= slot_col(cmp_idx_q);
						res_q.slot_row    <= slot_rw(cmp_idx_q);
						last_slot_q       <= cmp_idx_q;
						last_valid_q      <= 1'b1;
						cmp_valid_q       <= 1'b0;
						state_q           <= ST_DONE;
					end else if (scan_idx_q < count_q) begin
						cmp_valid_q <= 1'b1;
						cmp_idx_q   <= scan_idx_q[SLOT_W-1:0];
						scan_idx_q  <= scan_idx_q + COUNT_W'(1);
					end else begin
						cmp_valid_q <= 1'b0;
						state_q     <= ST_ALLOC;
					end
				end
				ST_ALLOC: begin
					count_q            <= COUNT_W'(alloc_idx) + COUNT_W'(1);
					last_slot_q        <= alloc_idx;
					last_valid_q       <= 1'b1;
					dirty_q            <= 1'b1;
					res_q.fetch_needed <= 1'b1;
					res_q.flushed      <= full;
					res_q.slot         <= alloc_idx;
					res_q.slot_column  <= slot_col(alloc_idx);
					res_q.slot_row     <= slot_rw(alloc_idx);
					state_q            <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks on occupancy and allocation bookkeeping.
	`TSCA_ASSERT(a_count_bound, clk, arst_n, count_q <= COUNT_W'(SLOT_COUNT))
	`TSCA_ASSERT(a_last_in_range, clk, arst_n, last_valid_q |-> (COUNT_W'(last_slot_q) < count_q))
	`TSCA_ASSERT(a_alloc_count, clk, arst_n, wr_en |=> (count_q == COUNT_W'($past(wr_addr)) + COUNT_W'(1)))
	`TSCA_NEVER(a_hit_no_fetch, clk, arst_n, done && res_q.hit && res_q.fetch_needed)

endmodule

FILE: rtl/core/tile_slot_cache_allocator.sv
// Tile slot cache allocator top level: stream ports, key forming and result register.
//
// Keeps a page of 64 tile slots. A tile request (action 0) forms the key
// tile + page * 1255, checks the last-hit slot and then the active slots in
// fill order, and returns the matching slot or allocates the next one,
// flushing a full page first. Release (action 1) empties the page; upload
// check (action 2) reports and clears the dirty flag. One request is worked
// on at a time and s_axis_tready is low meanwhile. The next request can be
// accepted at the same edge at which the result can first be taken. The
// scan is paced by the single read port of the slot tag memory, which
// feeds one comparator one entry per cycle. A finished result waits in the
// output register, so the next request can be accepted before it is taken.
module tile_slot_cache_allocator #(
	parameter logic [15:0] TILES_PER_PAGE_KEY = tsca_pkg::TILES_PER_PAGE_KEY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // source_id[7:0], page_number[15:8], tile_number[26:16], zeros
	input  logic [1:0]  s_axis_tuser,  // action[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // hit, slot[6:1], fetch_needed, flushed,
	                                   // slot_column[11:9], slot_row[14:12], was_dirty
);
	import tsca_pkg::*;

	localparam int PROD_W = PAGE_W + $bits(TILES_PER_PAGE_KEY);

	logic              start;
	logic              out_free;
	logic              seq_idle;
	logic              seq_done;
	req_t              req;
	res_t              res;
	logic [PROD_W-1:0] key_full;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	entry_t            wr_data;
	logic [SLOT_W-1:0] rd_addr;
	entry_t            rd_data;
	logic              m_valid_q;
	logic [15:0]       m_data_q;

	// Request handshake.
	assign s_axis_tready = seq_idle;
	assign start         = s_axis_tvalid && seq_idle;

	// Key forming: one small multiply and add, kept to the key width.
	assign key_full = PROD_W'(s_axis_tdata[15:8]) * PROD_W'(TILES_PER_PAGE_KEY)
		+ PROD_W'(s_axis_tdata[26:16]);

	assign req.action    = s_axis_tuser;
	assign req.source_id = s_axis_tdata[7:0];
	assign req.key       = key_full[KEY_W-1:0];

	tsca_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.out_free (out_free),
		.idle     (seq_idle),
		.done     (seq_done),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	tsca_slot_mem u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Output register; free when empty or being taken this cycle.
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else if (seq_done && out_free) begin
			m_valid_q <= 1'b1;
			m_data_q  <= {res.was_dirty, res.slot_row, res.slot_column, res.flushed,
				res.fetch_needed, res.slot, res.hit};
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

FILE: tb/tile_slot_cache_allocator_test.sv
// Testbench for the tile slot cache allocator: stream stimulus and a predicting scoreboard.
module tile_slot_cache_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tsca_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int ITEM_TARGET   = 1200;
	localparam int DRAIN_CYCLES  = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AT       = 300;
	localparam int SET_MAX       = 100;

	// Predicts the slot lookup and keeps the results still owed by the block.
	class slot_scoreboard;
		logic [KEY_W-1:0]  key_at[SLOT_COUNT];
		logic [SRC_W-1:0]  source_at[SLOT_COUNT];
		int unsigned       filled;
		logic [SLOT_W-1:0] last_hit;
		bit                last_ok;
		bit                dirty;
		res_t              owed[$];
		int                errors;

		function new();
			filled   = 0;
			last_hit = '0;
			last_ok  = 1'b0;
			dirty    = 1'b0;
			errors   = 0;
		endfunction

		// Slot index with its column and row on the page.
		function res_t place(int unsigned s);
			res_t r;
			r = '0;
			r.slot        = SLOT_W'(s);
			r.slot_column = POS_W'(s % TILES_PER_SIDE);
			r.slot_row    = POS_W'(s / TILES_PER_SIDE);
			return r;
		endfunction

		// Tile lookup: last hit first, then a scan of the active slots, else allocate.
		function res_t lookup(logic [SRC_W-1:0] src, logic [KEY_W-1:0] key);
			res_t r;
			bit   emptied;
			emptied = 1'b0;
			if (last_ok && source_at[last_hit] == src && key_at[last_hit] == key) begin
				r = place(last_hit);
				r.hit = 1'b1;
				return r;
			end
			for (int unsigned i = 0; i < filled; i++) begin
				if (source_at[i] == src && key_at[i] == key) begin
					last_hit = SLOT_W'(i);
					last_ok  = 1'b1;
					r = place(i);
					r.hit = 1'b1;
					return r;
				end
			end
			// A full page is flushed and filling starts over at slot 0.
			if (filled >= SLOT_COUNT) begin
				filled  = 0;
				emptied = 1'b1;
			end
			r = place(filled);
			r.fetch_needed = 1'b1;
			r.flushed      = emptied;
			key_at[filled]    = key;
			source_at[filled] = src;
			last_hit = SLOT_W'(filled);
			last_ok  = 1'b1;
			filled   = filled + 1;
			dirty    = 1'b1;
			return r;
		endfunction

		// Called for every accepted request.
		function void note_request(logic [ACT_W-1:0] act, logic [SRC_W-1:0] src,
				logic [PAGE_W-1:0] page, logic [TILE_W-1:0] tile);
			res_t             r;
			logic [KEY_W-1:0] key;
			r   = '0;
			key = KEY_W'(int'(tile) + int'(page) * int'(TILES_PER_PAGE_KEY));
			case (act)
				ACT_REQUEST: begin
					r = lookup(src, key);
				end
				ACT_RELEASE: begin
					// The dirty flag survives a release.
					filled   = 0;
					last_hit = '0;
					last_ok  = 1'b0;
				end
				ACT_UPLOAD: begin
					r.was_dirty = dirty;
					dirty = 1'b0;
				end
				default: begin
				end
			endcase
			owed.push_back(r);
		endfunction

		function void compare(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// Called for every result taken from the block.
		function void check_result(logic [15:0] d);
			res_t want;
			if (owed.size() == 0) begin
				$error("result %h arrived with no request outstanding", d);
				errors++;
				return;
			end
			want = owed.pop_front();
			compare("hit", want.hit, d[0]);
			compare("slot", want.slot, d[6:1]);
			compare("fetch_needed", want.fetch_needed, d[7]);
			compare("flushed", want.flushed, d[8]);
			compare("slot_column", want.slot_column, d[11:9]);
			compare("slot_row", want.slot_row, d[14:12]);
			compare("was_dirty", want.was_dirty, d[15]);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	slot_scoreboard board = new();
	bit             calm = 1'b0;
	int             offered = 0;
	int             results_seen = 0;
	int             hold_left = 0;
	bit             hold_done = 1'b0;
	int             cycles = 0;

	tile_slot_cache_allocator uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #6 clk = ~clk;

	// Give up on a hung block.
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tile_slot_cache_allocator_test failed");
			$finish;
		end
	end

	// Result side: check each accepted result, stall at random, and once hold off long.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			board.check_result(m_axis_tdata);
			results_seen = results_seen + 1;
		end
		if (!hold_done && results_seen == HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
		end
	end

	// Offer one request, with a random gap first, and wait until it is taken.
	task automatic offer_request(logic [ACT_W-1:0] act, logic [SRC_W-1:0] src,
			logic [PAGE_W-1:0] page, logic [TILE_W-1:0] tile);
		while (!calm && $urandom_range(0, 99) < 33) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, tile, page, src};
		s_axis_tuser  <= act;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_request(act, src, page, tile);
		offered = offered + 1;
	endtask

	initial begin
		logic [SRC_W-1:0]  set_src[SET_MAX];
		logic [PAGE_W-1:0] set_page[SET_MAX];
		logic [TILE_W-1:0] set_tile[SET_MAX];
		logic [SRC_W-1:0]  base_src;
		int                set_size;
		int                burst_len;
		int                pick;
		int                choice;
		bit                sweep;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: dirty flag after reset, last-hit and scan hits, same key with
		// another source, extremes of the fields, release keeping the dirty flag.
		offer_request(ACT_UPLOAD, 8'd0, 8'd0, 11'd0);
		offer_request(ACT_REQUEST, 8'd0, 8'd0, 11'd0);
		offer_request(ACT_REQUEST, 8'd0, 8'd0, 11'd0);
		offer_request(ACT_REQUEST, 8'd255, 8'd255, 11'd1254);
		offer_request(ACT_REQUEST, 8'd0, 8'd0, 11'd0);
		offer_request(ACT_REQUEST, 8'd1, 8'd0, 11'd0);
		offer_request(ACT_REQUEST, 8'd0, 8'd1, 11'd0);
		offer_request(ACT_REQUEST, 8'd0, 8'd0, 11'd1255 - 11'd1);
		offer_request(ACT_UPLOAD, 8'd0, 8'd0, 11'd0);
		offer_request(ACT_UPLOAD, 8'd0, 8'd0, 11'd0);
		offer_request(ACT_REQUEST, 8'd255, 8'd255, 11'd1254);
		offer_request(ACT_UPLOAD, 8'd0, 8'd0, 11'd0);
		offer_request(ACT_REQUEST, 8'd170, 8'd85, 11'd1024);
		offer_request(ACT_RELEASE, 8'd255, 8'd255, 11'd1254);
		offer_request(ACT_UPLOAD, 8'd255, 8'd255, 11'd1254);
		offer_request(ACT_REQUEST, 8'd255, 8'd255, 11'd1254);
		offer_request(ACT_REQUEST, 8'd0, 8'd0, 11'd0);
		offer_request(ACT_RELEASE, 8'd0, 8'd0, 11'd0);
		offer_request(ACT_REQUEST, 8'd0, 8'd0, 11'd0);

		// Random: mostly bursts over a working set, with releases, uploads and noise.
		while (offered < ITEM_TARGET) begin
			calm = (offered >= 500 && offered < 700);
			choice = $urandom_range(0, 99);
			if (choice < 8) begin
				offer_request(ACT_RELEASE, SRC_W'($urandom), PAGE_W'($urandom),
					TILE_W'($urandom_range(0, 1254)));
			end else if (choice < 16) begin
				offer_request(ACT_UPLOAD, SRC_W'($urandom), PAGE_W'($urandom),
					TILE_W'($urandom_range(0, 1254)));
			end else if (choice < 26) begin
				offer_request(ACT_REQUEST, SRC_W'($urandom), PAGE_W'($urandom),
					TILE_W'($urandom_range(0, 1254)));
			end else begin
				// Build a working set; some sizes overflow the page to force a flush.
				case ($urandom_range(0, 4))
					0: set_size = 6;
					1: set_size = 40;
					2: set_size = SLOT_COUNT;
					3: set_size = SLOT_COUNT + 2;
					default: set_size = SET_MAX;
				endcase
				base_src = SRC_W'($urandom);
				for (int i = 0; i < set_size; i++) begin
					if (i > 0 && $urandom_range(0, 7) == 0) begin
						// Same key as the previous member, other source.
						set_src[i]  = set_src[i-1] + 8'd1;
						set_page[i] = set_page[i-1];
						set_tile[i] = set_tile[i-1];
					end else begin
						set_src[i]  = ($urandom_range(0, 3) == 0) ? SRC_W'($urandom)
							: base_src + SRC_W'($urandom_range(0, 1));
						set_page[i] = PAGE_W'($urandom);
						set_tile[i] = TILE_W'($urandom_range(0, 1254));
					end
				end
				sweep     = (set_size >= SLOT_COUNT) && ($urandom_range(0, 1) == 1);
				burst_len = sweep ? set_size + $urandom_range(10, 40) : $urandom_range(20, 80);
				pick      = 0;
				for (int n = 0; n < burst_len; n++) begin
					choice = $urandom_range(0, 99);
					if (n > 0 && choice >= 30) begin
						pick = sweep ? (pick + 1) % set_size : $urandom_range(0, set_size - 1);
					end
					offer_request(ACT_REQUEST, set_src[pick], set_page[pick], set_tile[pick]);
				end
			end
		end
		s_axis_tvalid <= 1'b0;
		calm = 1'b0;

		// Drain, then watch for stray results.
		while (board.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.owed.size() == 0) begin
			$display("tile_slot_cache_allocator_test passed");
		end else begin
			$display("tile_slot_cache_allocator_test failed");
		end
		$finish;
	end

endmodule
